/* rtl/gbd_pkg.sv */
// Shared widths, codes, control word and microcode table of the Goertzel bin detector.
package gbd_pkg;

  // Field and state widths
  localparam int SAMPLE_BITS    = 16;
  localparam int STATE_BITS     = 40;
  localparam int COEF_BITS      = 16;
  localparam int COEF_FRAC_BITS = 14;
  localparam int LEN_BITS       = 13;
  localparam int MAX_FRAME      = 4096;
  localparam int MAG_BITS       = 40;

  // Configuration port
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;
  localparam logic [CFG_IDX_BITS-1:0] REG_COS = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SIN = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_LEN = 2'd2;

  localparam logic signed [COEF_BITS-1:0] COS_RESET = 16'sd15986;
  localparam logic signed [COEF_BITS-1:0] SIN_RESET = 16'sd3590;
  localparam logic [LEN_BITS-1:0]         LEN_RESET = 13'd256;

  // Shared multiplier: squares are split into a low and a high half of the operand
  localparam int HALF_BITS  = STATE_BITS / 2;
  localparam int HI_BITS    = STATE_BITS - HALF_BITS;
  localparam int MUL_A_BITS = STATE_BITS + 1;
  localparam int MUL_B_BITS = HI_BITS + 1;
  localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;
  localparam int SQ_BITS    = STATE_BITS + HI_BITS;
  localparam int WIDE_BITS  = PROD_BITS + 2;

  // Square root unit
  localparam int ACC_BITS   = 2 * STATE_BITS;
  localparam int ROOT_BITS  = STATE_BITS;
  localparam int REM_BITS   = ROOT_BITS + 2;
  localparam int TRIAL_BITS = REM_BITS + 2;
  localparam int SQRT_ITERS = ROOT_BITS;
  localparam int LOOP_BITS  = $clog2(SQRT_ITERS);

  typedef logic signed [STATE_BITS-1:0] state_t;

  localparam logic signed [WIDE_BITS-1:0] SAT_HI =
    {{(WIDE_BITS-STATE_BITS+1){1'b0}}, {(STATE_BITS-1){1'b1}}};
  localparam logic signed [WIDE_BITS-1:0] SAT_LO = ~SAT_HI;

  // Datapath operations
  localparam int OP_BITS = 4;
  localparam logic [OP_BITS-1:0] OP_NOP       = 4'd0;
  localparam logic [OP_BITS-1:0] OP_NEW_S     = 4'd1;
  localparam logic [OP_BITS-1:0] OP_SHIFT     = 4'd2;
  localparam logic [OP_BITS-1:0] OP_RE        = 4'd3;
  localparam logic [OP_BITS-1:0] OP_IM        = 4'd4;
  localparam logic [OP_BITS-1:0] OP_ACC_LOAD  = 4'd5;
  localparam logic [OP_BITS-1:0] OP_ACC_ADDHI = 4'd6;
  localparam logic [OP_BITS-1:0] OP_ACC_ADD   = 4'd7;
  localparam logic [OP_BITS-1:0] OP_ACC_LAST  = 4'd8;
  localparam logic [OP_BITS-1:0] OP_SQRT      = 4'd9;
  localparam logic [OP_BITS-1:0] OP_FINISH    = 4'd10;
  localparam logic [OP_BITS-1:0] OP_EMIT      = 4'd11;

  // Multiplier operand selection
  localparam int MS_BITS = 3;
  localparam logic [MS_BITS-1:0] MS_S1_COS = 3'd0;
  localparam logic [MS_BITS-1:0] MS_SN_COS = 3'd1;
  localparam logic [MS_BITS-1:0] MS_SN_SIN = 3'd2;
  localparam logic [MS_BITS-1:0] MS_RE_LO  = 3'd3;
  localparam logic [MS_BITS-1:0] MS_RE_HI  = 3'd4;
  localparam logic [MS_BITS-1:0] MS_IM_LO  = 3'd5;
  localparam logic [MS_BITS-1:0] MS_IM_HI  = 3'd6;

  // Jump conditions
  localparam int JC_BITS = 3;
  localparam logic [JC_BITS-1:0] JC_NEVER   = 3'd0;
  localparam logic [JC_BITS-1:0] JC_ALWAYS  = 3'd1;
  localparam logic [JC_BITS-1:0] JC_IDLE    = 3'd2;
  localparam logic [JC_BITS-1:0] JC_NOT_END = 3'd3;
  localparam logic [JC_BITS-1:0] JC_LOOP    = 3'd4;
  localparam logic [JC_BITS-1:0] JC_BUSY    = 3'd5;

  // Program steps
  localparam int STEP_BITS = 4;
  localparam logic [STEP_BITS-1:0] ST_IDLE    = 4'd0;
  localparam logic [STEP_BITS-1:0] ST_MUL_S1  = 4'd1;
  localparam logic [STEP_BITS-1:0] ST_NEW_S   = 4'd2;
  localparam logic [STEP_BITS-1:0] ST_BRANCH  = 4'd3;
  localparam logic [STEP_BITS-1:0] ST_RE      = 4'd4;
  localparam logic [STEP_BITS-1:0] ST_IM      = 4'd5;
  localparam logic [STEP_BITS-1:0] ST_SQ_RE0  = 4'd6;
  localparam logic [STEP_BITS-1:0] ST_SQ_RE1  = 4'd7;
  localparam logic [STEP_BITS-1:0] ST_SQ_IM0  = 4'd8;
  localparam logic [STEP_BITS-1:0] ST_SQ_IM1  = 4'd9;
  localparam logic [STEP_BITS-1:0] ST_SQRT    = 4'd10;
  localparam logic [STEP_BITS-1:0] ST_FINISH  = 4'd11;
  localparam logic [STEP_BITS-1:0] ST_EMIT    = 4'd12;
  localparam logic [STEP_BITS-1:0] ST_RETURN  = 4'd13;

  typedef struct packed {
    logic [OP_BITS-1:0]   op;
    logic [MS_BITS-1:0]   mul_sel;
    logic [JC_BITS-1:0]   cond;
    logic [STEP_BITS-1:0] target;
    logic                 loop_load;
  } ctrl_word_t;

  typedef struct packed {
    logic item_in;
    logic frame_end;
    logic out_busy;
  } seq_status_t;

  // Saturate a wide signed value to the resonator range
  function automatic state_t sat_state(input logic signed [WIDE_BITS-1:0] v);
    state_t r;
    if (v > SAT_HI) r = SAT_HI[STATE_BITS-1:0];
    else if (v < SAT_LO) r = SAT_LO[STATE_BITS-1:0];
    else r = v[STATE_BITS-1:0];
    return r;
  endfunction

  function automatic logic [STATE_BITS-1:0] abs_state(input state_t v);
    logic [STATE_BITS-1:0] r;
    r = v[STATE_BITS-1] ? STATE_BITS'(-v) : STATE_BITS'(v);
    return r;
  endfunction

  // Microcode: one control word per step
  function automatic ctrl_word_t ucode_rom(input logic [STEP_BITS-1:0] step);
    ctrl_word_t cw;
    unique case (step)
      ST_IDLE:   cw = '{op: OP_NOP,       mul_sel: MS_S1_COS, cond: JC_IDLE,
                        target: ST_IDLE,   loop_load: 1'b0};
      ST_MUL_S1: cw = '{op: OP_NOP,       mul_sel: MS_S1_COS, cond: JC_NEVER,
                        target: ST_IDLE,   loop_load: 1'b0};
      ST_NEW_S:  cw = '{op: OP_NEW_S,     mul_sel: MS_S1_COS, cond: JC_NEVER,
                        target: ST_IDLE,   loop_load: 1'b0};
      ST_BRANCH: cw = '{op: OP_SHIFT,     mul_sel: MS_SN_COS, cond: JC_NOT_END,
                        target: ST_EMIT,   loop_load: 1'b0};
      ST_RE:     cw = '{op: OP_RE,        mul_sel: MS_SN_SIN, cond: JC_NEVER,
                        target: ST_IDLE,   loop_load: 1'b0};
      ST_IM:     cw = '{op: OP_IM,        mul_sel: MS_RE_LO,  cond: JC_NEVER,
                        target: ST_IDLE,   loop_load: 1'b0};
      ST_SQ_RE0: cw = '{op: OP_ACC_LOAD,  mul_sel: MS_RE_HI,  cond: JC_NEVER,
                        target: ST_IDLE,   loop_load: 1'b0};
      ST_SQ_RE1: cw = '{op: OP_ACC_ADDHI, mul_sel: MS_IM_LO,  cond: JC_NEVER,
                        target: ST_IDLE,   loop_load: 1'b0};
      ST_SQ_IM0: cw = '{op: OP_ACC_ADD,   mul_sel: MS_IM_HI,  cond: JC_NEVER,
                        target: ST_IDLE,   loop_load: 1'b0};
      ST_SQ_IM1: cw = '{op: OP_ACC_LAST,  mul_sel: MS_S1_COS, cond: JC_NEVER,
                        target: ST_IDLE,   loop_load: 1'b1};
      ST_SQRT:   cw = '{op: OP_SQRT,      mul_sel: MS_S1_COS, cond: JC_LOOP,
                        target: ST_SQRT,   loop_load: 1'b0};
      ST_FINISH: cw = '{op: OP_FINISH,    mul_sel: MS_S1_COS, cond: JC_NEVER,
                        target: ST_IDLE,   loop_load: 1'b0};
      ST_EMIT:   cw = '{op: OP_EMIT,      mul_sel: MS_S1_COS, cond: JC_BUSY,
                        target: ST_EMIT,   loop_load: 1'b0};
      ST_RETURN: cw = '{op: OP_NOP,       mul_sel: MS_S1_COS, cond: JC_ALWAYS,
                        target: ST_IDLE,   loop_load: 1'b0};
      default:   cw = '{op: OP_NOP,       mul_sel: MS_S1_COS, cond: JC_ALWAYS,
                        target: ST_IDLE,   loop_load: 1'b0};
    endcase
    return cw;
  endfunction

endpackage

/* rtl/gbd_channels.sv */
// Valid/ready channel interfaces for samples, results and configuration writes.
interface gbd_sample_if;
  import gbd_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface gbd_result_if;
  import gbd_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [STATE_BITS-1:0] resonator_out;
  logic                         frame_end;
  logic [MAG_BITS-1:0]          bin_magnitude;
  modport source (output valid, output resonator_out, output frame_end,
                  output bin_magnitude, input ready);
  modport sink (input valid, input resonator_out, input frame_end,
                input bin_magnitude, output ready);
endinterface

interface gbd_cfg_if;
  import gbd_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/gbd_sequencer.sv */
// Microcode sequencer: step counter, control table lookup, conditional jumps and loop count.
module gbd_sequencer (
  input  logic                 clk,
  input  logic                 rst,
  input  gbd_pkg::seq_status_t status,
  output gbd_pkg::ctrl_word_t  ctrl,
  output logic                 idle
);
  import gbd_pkg::*;

  logic [STEP_BITS-1:0] step;
  logic [STEP_BITS-1:0] step_next;
  logic [LOOP_BITS-1:0] loop;
  logic                 take;

  // Fetch the control word of the current step
  assign ctrl = ucode_rom(step);
  assign idle = (step == ST_IDLE);

  // Evaluate the jump condition
  always_comb begin
    unique case (ctrl.cond)
      JC_NEVER:   take = 1'b0;
      JC_ALWAYS:  take = 1'b1;
      JC_IDLE:    take = !status.item_in;
      JC_NOT_END: take = !status.frame_end;
      JC_LOOP:    take = (loop != '0);
      JC_BUSY:    take = status.out_busy;
      default:    take = 1'b1;
    endcase
    step_next = take ? ctrl.target : step + 1'b1;
  end

  // Advance step and loop counters
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
      loop <= '0;
    end else begin
      step <= step_next;
      if (ctrl.loop_load) begin
        loop <= LOOP_BITS'(SQRT_ITERS - 1);
      end else if (ctrl.cond == JC_LOOP && loop != '0) begin
        loop <= loop - 1'b1;
      end
    end
  end

endmodule

/* rtl/gbd_datapath.sv */
// Datapath: resonator state, shared multiplier, sum of squares and bit-pair square root.
module gbd_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  gbd_pkg::ctrl_word_t                   ctrl,
  input  logic                                  item_in,
  input  logic signed [gbd_pkg::SAMPLE_BITS-1:0] sample,
  input  logic signed [gbd_pkg::COEF_BITS-1:0]   cos_coef,
  input  logic signed [gbd_pkg::COEF_BITS-1:0]   sin_coef,
  input  logic [gbd_pkg::LEN_BITS-1:0]           frame_length,
  output gbd_pkg::state_t                       s_new,
  output logic                                  frame_end,
  output logic [gbd_pkg::MAG_BITS-1:0]          held_mag
);
  import gbd_pkg::*;

  state_t                         s1;
  state_t                         s2;
  logic [LEN_BITS-1:0]            count;
  logic signed [SAMPLE_BITS-1:0]  x;
  logic signed [PROD_BITS-1:0]    prod;
  logic [STATE_BITS-1:0]          re_abs;
  logic [STATE_BITS-1:0]          im_abs;
  logic [ACC_BITS-1:0]            acc;
  logic [REM_BITS-1:0]            rem;
  logic [ROOT_BITS-1:0]           root;

  logic signed [MUL_A_BITS-1:0]   mul_a;
  logic signed [MUL_B_BITS-1:0]   mul_b;
  logic signed [WIDE_BITS-1:0]    prod_w;
  logic signed [WIDE_BITS-1:0]    new_sum;
  logic signed [WIDE_BITS-1:0]    re_sum;
  logic signed [WIDE_BITS-1:0]    im_sum;
  logic [ACC_BITS-1:0]            sq;
  logic [LEN_BITS-1:0]            len_eff;
  logic [LEN_BITS:0]              cnt_inc;
  logic                           end_hit;
  logic [TRIAL_BITS-1:0]          rem_t;
  logic [TRIAL_BITS-1:0]          trial;
  logic                           fits;

  // Pick multiplier operands
  always_comb begin
    unique case (ctrl.mul_sel)
      MS_S1_COS: begin
        mul_a = MUL_A_BITS'(s1);
        mul_b = MUL_B_BITS'(cos_coef);
      end
      MS_SN_COS: begin
        mul_a = MUL_A_BITS'(s_new);
        mul_b = MUL_B_BITS'(cos_coef);
      end
      MS_SN_SIN: begin
        mul_a = MUL_A_BITS'(s_new);
        mul_b = MUL_B_BITS'(sin_coef);
      end
      MS_RE_LO: begin
        mul_a = signed'({1'b0, re_abs});
        mul_b = signed'(MUL_B_BITS'(re_abs[HALF_BITS-1:0]));
      end
      MS_RE_HI: begin
        mul_a = signed'({1'b0, re_abs});
        mul_b = signed'({1'b0, re_abs[STATE_BITS-1:HALF_BITS]});
      end
      MS_IM_LO: begin
        mul_a = signed'({1'b0, im_abs});
        mul_b = signed'(MUL_B_BITS'(im_abs[HALF_BITS-1:0]));
      end
      MS_IM_HI: begin
        mul_a = signed'({1'b0, im_abs});
        mul_b = signed'({1'b0, im_abs[STATE_BITS-1:HALF_BITS]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Resonator sums, frame counting and square root trial
  always_comb begin
    prod_w  = WIDE_BITS'(prod);
    new_sum = (prod_w >>> (COEF_FRAC_BITS - 1)) + WIDE_BITS'(x) - WIDE_BITS'(s2);
    re_sum  = (prod_w >>> COEF_FRAC_BITS) - WIDE_BITS'(s1);
    im_sum  = prod_w >>> COEF_FRAC_BITS;
    sq      = ACC_BITS'(prod[SQ_BITS-1:0]);

    if (frame_length == '0) len_eff = LEN_BITS'(1);
    else if (frame_length > LEN_BITS'(MAX_FRAME)) len_eff = LEN_BITS'(MAX_FRAME);
    else len_eff = frame_length;
    cnt_inc = {1'b0, count} + 1'b1;
    end_hit = (cnt_inc >= {1'b0, len_eff});

    rem_t = {rem, acc[ACC_BITS-1 -: 2]};
    trial = TRIAL_BITS'({root, 2'b01});
    fits  = (rem_t >= trial);
  end

  // Multiply and latch the sample on acceptance
  always_ff @(posedge clk) begin
    prod <= PROD_BITS'(mul_a * mul_b);
    if (item_in) begin
      x <= sample;
    end
  end

  // Execute the operation of the current step
  always_ff @(posedge clk) begin
    if (rst) begin
      s1        <= '0;
      s2        <= '0;
      count     <= '0;
      held_mag  <= '0;
      frame_end <= 1'b0;
    end else begin
      unique case (ctrl.op)
        OP_NEW_S: begin
          s_new     <= sat_state(new_sum);
          frame_end <= end_hit;
          count     <= end_hit ? '0 : cnt_inc[LEN_BITS-1:0];
        end
        OP_SHIFT: begin
          if (!frame_end) begin
            s2 <= s1;
            s1 <= s_new;
          end
        end
        OP_RE:        re_abs <= abs_state(sat_state(re_sum));
        OP_IM:        im_abs <= abs_state(sat_state(im_sum));
        OP_ACC_LOAD:  acc <= sq;
        OP_ACC_ADDHI: acc <= acc + (sq << HALF_BITS);
        OP_ACC_ADD:   acc <= acc + sq;
        OP_ACC_LAST: begin
          acc  <= acc + (sq << HALF_BITS);
          rem  <= '0;
          root <= '0;
        end
        OP_SQRT: begin
          acc <= acc << 2;
          if (fits) begin
            rem  <= REM_BITS'(rem_t - trial);
            root <= {root[ROOT_BITS-2:0], 1'b1};
          end else begin
            rem  <= REM_BITS'(rem_t);
            root <= {root[ROOT_BITS-2:0], 1'b0};
          end
        end
        OP_FINISH: begin
          held_mag <= MAG_BITS'(root);
          s1       <= '0;
          s2       <= '0;
        end
        OP_NOP, OP_EMIT: begin
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* rtl/goertzel_bin_detector.sv */
// A sample that does not end a frame passes the steps MUL_S1, NEW_S, BRANCH, EMIT and RETURN;
// no new sample is taken until the program is back at IDLE; EMIT waits while a beat is untaken.
// A frame-ending sample also passes RE, IM, the four squaring steps and the square root loop
// of 40 bit-pair steps before FINISH, EMIT and RETURN, and no new sample is taken meanwhile.
// Reset (synchronous, active high) clears resonator state, sample count, held magnitude and
// the output valid flag, and loads cos_coef 15986, sin_coef 3590, frame_length 256.
module goertzel_bin_detector (
  input logic   clk,
  input logic   rst,
  gbd_sample_if.sink   audio,
  gbd_result_if.source result,
  gbd_cfg_if.sink      cfg
);
  import gbd_pkg::*;

  logic signed [COEF_BITS-1:0] cos_coef;
  logic signed [COEF_BITS-1:0] sin_coef;
  logic [LEN_BITS-1:0]         frame_length;

  ctrl_word_t          ctrl;
  seq_status_t         status;
  logic                idle;
  logic                item_in;
  logic                emit;
  state_t              s_new;
  logic                frame_end;
  logic [MAG_BITS-1:0] held_mag;

  // Input handshake: take a sample whenever the program rests at its first step
  assign audio.ready = idle;
  assign item_in     = audio.valid && audio.ready;

  assign status.item_in   = item_in;
  assign status.frame_end = frame_end;
  assign status.out_busy  = result.valid && !result.ready;
  assign emit             = (ctrl.op == OP_EMIT) && !status.out_busy;

  // Configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_coef     <= COS_RESET;
      sin_coef     <= SIN_RESET;
      frame_length <= LEN_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_COS: cos_coef     <= signed'(cfg.data[COEF_BITS-1:0]);
        REG_SIN: sin_coef     <= signed'(cfg.data[COEF_BITS-1:0]);
        REG_LEN: frame_length <= cfg.data[LEN_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  gbd_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl),
    .idle   (idle)
  );

  gbd_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .item_in      (item_in),
    .sample       (audio.sample),
    .cos_coef     (cos_coef),
    .sin_coef     (sin_coef),
    .frame_length (frame_length),
    .s_new        (s_new),
    .frame_end    (frame_end),
    .held_mag     (held_mag)
  );

  // Output register: load a beat on emit, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (emit) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result.resonator_out <= s_new;
      result.frame_end     <= frame_end;
      result.bin_magnitude <= held_mag;
    end
  end

endmodule
